### rtl/core/bwm_pkg.sv
// Package for the breakpoint/watchpoint matcher: field widths, command,
// table and status codes, the controller-to-datapath command struct, and
// command decode functions. No dependencies.
package bwm_pkg;

  localparam int CMD_W    = 4;
  localparam int ADDR_W   = 32;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_BREAK   = 4'd0,
    CMD_DEL_BREAK   = 4'd1,
    CMD_ADD_READ    = 4'd2,
    CMD_DEL_READ    = 4'd3,
    CMD_ADD_WRITE   = 4'd4,
    CMD_DEL_WRITE   = 4'd5,
    CMD_CHECK_PC    = 4'd6,
    CMD_CHECK_READ  = 4'd7,
    CMD_CHECK_WRITE = 4'd8
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_PRESENT   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_ADD   = 2'd1,
    OP_DEL   = 2'd2,
    OP_CHECK = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    TBL_BREAK = 2'd0,
    TBL_READ  = 2'd1,
    TBL_WRITE = 2'd2
  } tbl_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the input item
    logic compare;  // register the per-entry match vector
    logic commit;   // update the table and load the result register
  } ctrl_t;

  function automatic op_t cmd_op(logic [CMD_W-1:0] c);
    op_t op;
    case (c)
      CMD_ADD_BREAK, CMD_ADD_READ, CMD_ADD_WRITE:   op = OP_ADD;
      CMD_DEL_BREAK, CMD_DEL_READ, CMD_DEL_WRITE:   op = OP_DEL;
      CMD_CHECK_PC, CMD_CHECK_READ, CMD_CHECK_WRITE: op = OP_CHECK;
      default:                                      op = OP_NONE;
    endcase
    return op;
  endfunction

  function automatic tbl_t cmd_tbl(logic [CMD_W-1:0] c);
    tbl_t t;
    case (c)
      CMD_ADD_READ, CMD_DEL_READ, CMD_CHECK_READ:    t = TBL_READ;
      CMD_ADD_WRITE, CMD_DEL_WRITE, CMD_CHECK_WRITE: t = TBL_WRITE;
      default:                                       t = TBL_BREAK;
    endcase
    return t;
  endfunction

endpackage

### rtl/core/bwm_req_if.sv
// Request channel of the breakpoint/watchpoint matcher: command and address.
// Depends on bwm_pkg.
interface bwm_req_if;
  import bwm_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output command, output address, input ready);
  modport sink   (input valid, input command, input address, output ready);
endinterface

### rtl/core/bwm_rsp_if.sv
// Response channel of the breakpoint/watchpoint matcher: hit and status.
// Depends on bwm_pkg.
interface bwm_rsp_if;
  import bwm_pkg::*;

  logic                valid;
  logic                ready;
  logic                hit;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output hit, output status, input ready);
  modport sink   (input valid, input hit, input status, output ready);
endinterface

### rtl/core/bwm_ctrl.sv
// Controller of the breakpoint/watchpoint matcher: sequences load, compare
// and commit, and owns both handshakes. Depends on bwm_pkg.
module bwm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output bwm_pkg::ctrl_t ctl
);
  import bwm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE    = 3'b001,
    S_COMPARE = 3'b010,
    S_COMMIT  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  // The result register can take a new result when empty or being drained.
  assign out_free = !rsp_valid || rsp_ready;

  always_comb begin
    ctl         = '0;
    req_ready   = 1'b0;
    state_next  = state;
    case (state)
      S_IDLE: begin
        // No transfer is taken while reset holds the state machine.
        req_ready = !rst;
        if (req_valid) begin
          state_next = S_COMPARE;
        end
      end
      S_COMPARE: begin
        ctl.compare = 1'b1;
        state_next  = S_COMMIT;
      end
      S_COMMIT: begin
        if (out_free) begin
          ctl.commit = 1'b1;
          req_ready  = 1'b1;
          state_next = req_valid ? S_COMPARE : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    ctl.load = req_valid && req_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_commit_shows_result: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |=> rsp_valid)
    else $error("committed result not presented");

  a_load_starts_compare: assert property (@(posedge clk) disable iff (rst)
    ctl.load |=> state == S_COMPARE)
    else $error("accepted item did not enter compare");

  a_compare_then_commit: assert property (@(posedge clk) disable iff (rst)
    ctl.compare |=> state == S_COMMIT)
    else $error("compare not followed by commit state");

endmodule

### rtl/core/bwm_datapath.sv
// Datapath of the breakpoint/watchpoint matcher: the three address tables
// with their valid bits, the match vector register and the result register.
// Depends on bwm_pkg.
module bwm_datapath #(
  parameter int ENTRIES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bwm_pkg::ctrl_t                ctl,
  input  logic [bwm_pkg::CMD_W-1:0]     req_command,
  input  logic [bwm_pkg::ADDR_W-1:0]    req_address,
  output logic                          rsp_hit,
  output logic [bwm_pkg::STATUS_W-1:0]  rsp_status
);
  import bwm_pkg::*;

  logic [CMD_W-1:0]   command;
  logic [ADDR_W-1:0]  address;
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] match_next;

  logic [ADDR_W-1:0]  break_addr [ENTRIES];
  logic [ADDR_W-1:0]  read_addr  [ENTRIES];
  logic [ADDR_W-1:0]  write_addr [ENTRIES];
  logic [ENTRIES-1:0] break_valid;
  logic [ENTRIES-1:0] read_valid;
  logic [ENTRIES-1:0] write_valid;

  op_t                op;
  tbl_t               tbl;
  logic [ADDR_W-1:0]  sel_addr [ENTRIES];
  logic [ENTRIES-1:0] sel_valid;
  logic [ENTRIES-1:0] free;
  logic [ENTRIES-1:0] first_free;
  logic [ENTRIES-1:0] valid_upd;
  logic               found;
  logic               wr_en;
  logic               hit_next;
  status_t            status_next;

  always_comb begin
    op  = cmd_op(command);
    tbl = cmd_tbl(command);
    case (tbl)
      TBL_READ: begin
        sel_addr  = read_addr;
        sel_valid = read_valid;
      end
      TBL_WRITE: begin
        sel_addr  = write_addr;
        sel_valid = write_valid;
      end
      default: begin
        sel_addr  = break_addr;
        sel_valid = break_valid;
      end
    endcase
    for (int i = 0; i < ENTRIES; i++) begin
      match_next[i] = sel_valid[i] && (sel_addr[i] == address);
    end
  end

  // Lowest free slot as a one-hot vector: isolate the lowest set bit.
  assign free       = ~sel_valid;
  assign first_free = free & ((~free) + ENTRIES'(1));
  assign found      = |match;

  always_comb begin
    hit_next    = 1'b0;
    status_next = ST_DONE;
    valid_upd   = sel_valid;
    wr_en       = 1'b0;
    case (op)
      OP_ADD: begin
        if (found) begin
          status_next = ST_PRESENT;
        end else if (free == '0) begin
          status_next = ST_FULL;
        end else begin
          valid_upd = sel_valid | first_free;
          wr_en     = 1'b1;
        end
      end
      OP_DEL: begin
        if (found) begin
          valid_upd = sel_valid & ~match;
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      OP_CHECK: begin
        hit_next = found;
      end
      default: begin
        hit_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      command <= req_command;
      address <= req_address;
    end
    if (ctl.compare) begin
      match <= match_next;
    end
    if (ctl.commit) begin
      rsp_hit    <= hit_next;
      rsp_status <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      break_valid <= '0;
      read_valid  <= '0;
      write_valid <= '0;
    end else if (ctl.commit) begin
      case (tbl)
        TBL_READ:  read_valid  <= valid_upd;
        TBL_WRITE: write_valid <= valid_upd;
        default:   break_valid <= valid_upd;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (ctl.commit && wr_en && first_free[i]) begin
        case (tbl)
          TBL_READ:  read_addr[i]  <= address;
          TBL_WRITE: write_addr[i] <= address;
          default:   break_addr[i] <= address;
        endcase
      end
    end
  end

  // A table never holds the same address twice, so at most one slot matches.
  a_single_match: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |-> $onehot0(match))
    else $error("address matched more than one slot");

  a_del_missing: assert property (@(posedge clk) disable iff (rst)
    ctl.commit && op == OP_DEL && !found |=> rsp_status == ST_NOT_FOUND)
    else $error("delete of absent address not flagged");

  a_hit_only_check: assert property (@(posedge clk) disable iff (rst)
    ctl.commit && op != OP_CHECK |=> !rsp_hit)
    else $error("hit reported for a non-check command");

endmodule

### rtl/core/breakpoint_watchpoint_matcher.sv
// Breakpoint/watchpoint matcher top level: controller plus datapath.
// A request passes a compare step across all slots of the selected table, then
// a commit step that presents the result; a stalled response holds commit. A new
// request is taken during the commit step, not during the compare step.
// Reset clears all valid bits at once; there is no clearing pass.
// Depends on bwm_pkg, bwm_req_if, bwm_rsp_if, bwm_ctrl and bwm_datapath.
module breakpoint_watchpoint_matcher #(
  parameter int ENTRIES = 16
) (
  input logic   clk,
  input logic   rst,
  bwm_req_if.sink   req,
  bwm_rsp_if.source rsp
);
  import bwm_pkg::*;

  ctrl_t ctl;

  bwm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .ctl       (ctl)
  );

  bwm_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .req_command (req.command),
    .req_address (req.address),
    .rsp_hit     (rsp.hit),
    .rsp_status  (rsp.status)
  );

endmodule

### test/tb_breakpoint_watchpoint_matcher.sv
// Testbench for breakpoint_watchpoint_matcher: a directed table followed by random
// add, delete, check and unused-code traffic, checked by a local predictor or typed rows.
// Depends on bwm_pkg, bwm_req_if, bwm_rsp_if and the breakpoint_watchpoint_matcher RTL.
module tb_breakpoint_watchpoint_matcher;
  timeunit 1ns;
  timeprecision 1ps;
  import bwm_pkg::*;

  localparam int ENTRIES        = 16;
  localparam int RANDOM_ITEMS   = 1525;
  localparam int POOL_SIZE      = 24;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int ADDR_STEP      = 4;

  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 4'd9;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 4'd15;

  typedef struct {
    logic    hit;
    status_t st;
  } watch_result_t;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    int                reps;
    bit                typed;
    logic              hit;
    status_t           st;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  bwm_req_if req_ch ();
  bwm_rsp_if rsp_ch ();

  breakpoint_watchpoint_matcher #(.ENTRIES(ENTRIES)) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  // Predicted contents of the three tables, indexed by tbl_t.
  logic [ADDR_W-1:0]  watch_addr  [3][ENTRIES];
  logic [ENTRIES-1:0] watch_valid [3];

  watch_result_t pending_results[$];
  stim_row_t     stim_rows[$];
  logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

  int mismatches   = 0;
  int quiet_cycles = 0;
  bit stim_done    = 1'b0;
  bit calm         = 1'b0;
  bit hold_rsp     = 1'b0;

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic int slot_of(tbl_t t, logic [ADDR_W-1:0] a);
    for (int i = 0; i < ENTRIES; i++)
      if (watch_valid[t][i] && watch_addr[t][i] == a) return i;
    return -1;
  endfunction

  function automatic watch_result_t predict_watch(logic [CMD_W-1:0] cmd,
                                                  logic [ADDR_W-1:0] a);
    watch_result_t r;
    tbl_t t;
    int s;
    r.hit = 1'b0;
    r.st  = ST_DONE;
    case (cmd)
      CMD_ADD_READ, CMD_DEL_READ, CMD_CHECK_READ:    t = TBL_READ;
      CMD_ADD_WRITE, CMD_DEL_WRITE, CMD_CHECK_WRITE: t = TBL_WRITE;
      default:                                       t = TBL_BREAK;
    endcase
    s = slot_of(t, a);
    case (cmd)
      CMD_ADD_BREAK, CMD_ADD_READ, CMD_ADD_WRITE: begin
        if (s >= 0) begin
          r.st = ST_PRESENT;
        end else begin
          r.st = ST_FULL;
          for (int i = 0; i < ENTRIES; i++) begin
            if (!watch_valid[t][i]) begin
              watch_addr[t][i]  = a;
              watch_valid[t][i] = 1'b1;
              r.st = ST_DONE;
              break;
            end
          end
        end
      end
      CMD_DEL_BREAK, CMD_DEL_READ, CMD_DEL_WRITE: begin
        if (s >= 0) watch_valid[t][s] = 1'b0;
        else r.st = ST_NOT_FOUND;
      end
      CMD_CHECK_PC, CMD_CHECK_READ, CMD_CHECK_WRITE: r.hit = (s >= 0);
      default: ;
    endcase
    return r;
  endfunction

  task automatic dir_row(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] a,
                         input int reps, input bit typed, input logic hit,
                         input status_t st);
    stim_row_t r;
    r.cmd   = cmd;
    r.addr  = a;
    r.reps  = reps;
    r.typed = typed;
    r.hit   = hit;
    r.st    = st;
    stim_rows.insert(stim_rows.size(), r);
  endtask

  // Offers one item after a random gap and records its expected result on transfer.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] a,
                           input bit typed, input logic thit, input status_t tst);
    int gap;
    watch_result_t want;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.command <= cmd;
    req_ch.address <= a;
    do @(posedge clk); while (!req_ch.ready);
    want = predict_watch(cmd, a);
    if (typed) begin
      want.hit = thit;
      want.st  = tst;
    end
    pending_results.insert(pending_results.size(), want);
  endtask

  initial begin : stimulus
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] a;
    int tsel, roll, add_pct, del_pct;
    rst            <= 1'b1;
    req_ch.valid   <= 1'b0;
    req_ch.command <= '0;
    req_ch.address <= '0;
    watch_valid = '{default: '0};

    dir_row(CMD_CHECK_PC,    32'h0000_0000, 1, 1, 1'b0, ST_DONE);
    dir_row(CMD_CHECK_READ,  32'hFFFF_FFFF, 1, 1, 1'b0, ST_DONE);
    dir_row(CMD_CHECK_WRITE, 32'h0000_0000, 1, 1, 1'b0, ST_DONE);
    dir_row(CMD_DEL_BREAK,   32'h0000_0000, 1, 1, 1'b0, ST_NOT_FOUND);
    dir_row(CMD_ADD_BREAK,   32'h0000_0000, 1, 1, 1'b0, ST_DONE);
    dir_row(CMD_ADD_BREAK,   32'h0000_0000, 1, 1, 1'b0, ST_PRESENT);
    dir_row(CMD_CHECK_PC,    32'h0000_0000, 1, 1, 1'b1, ST_DONE);
    dir_row(CMD_ADD_BREAK,   32'hFFFF_FFFF, 1, 0, 1'b0, ST_DONE);
    dir_row(CMD_CHECK_PC,    32'hFFFF_FFFF, 1, 0, 1'b0, ST_DONE);
    dir_row(CMD_CHECK_PC,    32'hFFFF_FFFE, 1, 0, 1'b0, ST_DONE);
    dir_row(CMD_ADD_READ,    32'hFFFF_FFFF, 1, 0, 1'b0, ST_DONE);
    dir_row(CMD_CHECK_READ,  32'hFFFF_FFFF, 1, 0, 1'b0, ST_DONE);
    dir_row(CMD_DEL_READ,    32'hFFFF_FFFF, 1, 1, 1'b0, ST_DONE);
    dir_row(CMD_DEL_READ,    32'hFFFF_FFFF, 1, 1, 1'b0, ST_NOT_FOUND);
    dir_row(CMD_CHECK_READ,  32'hFFFF_FFFF, 1, 1, 1'b0, ST_DONE);
    // Sixteen distinct adds fill the write table; the next new address is dropped,
    // while a duplicate still reports as present.
    dir_row(CMD_ADD_WRITE,   32'h0000_1000, ENTRIES, 0, 1'b0, ST_DONE);
    dir_row(CMD_ADD_WRITE,   32'h8000_0000, 1, 1, 1'b0, ST_FULL);
    dir_row(CMD_ADD_WRITE,   32'h0000_1000, 1, 1, 1'b0, ST_PRESENT);
    dir_row(CMD_CHECK_WRITE, 32'h0000_103C, 1, 0, 1'b0, ST_DONE);
    dir_row(CMD_DEL_WRITE,   32'h0000_1020, 1, 0, 1'b0, ST_DONE);
    dir_row(CMD_ADD_WRITE,   32'h8000_0000, 1, 0, 1'b0, ST_DONE);
    dir_row(CMD_CHECK_WRITE, 32'h8000_0000, 1, 0, 1'b0, ST_DONE);
    dir_row(CMD_UNUSED_LO,   32'h0000_0000, 1, 1, 1'b0, ST_DONE);
    dir_row(CMD_UNUSED_HI,   32'hFFFF_FFFF, 1, 1, 1'b0, ST_DONE);
    dir_row(CMD_DEL_BREAK,   32'h0000_0000, 1, 0, 1'b0, ST_DONE);
    dir_row(CMD_CHECK_PC,    32'h0000_0000, 1, 0, 1'b0, ST_DONE);

    addr_pool[0] = 32'h0000_0000;
    addr_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = $urandom;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[r])
      for (int k = 0; k < stim_rows[r].reps; k++)
        send_item(stim_rows[r].cmd, stim_rows[r].addr + k * ADDR_STEP,
                  stim_rows[r].typed, stim_rows[r].hit, stim_rows[r].st);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 400) hold_rsp = 1'b1;
      calm = (n >= 900 && n < 1100);
      // Phases lean toward adds, checks, deletes, then an even mix, so the tables
      // swing between empty and full.
      case ((n / 100) % 4)
        0: begin add_pct = 50; del_pct = 10; end
        1: begin add_pct = 15; del_pct = 10; end
        2: begin add_pct = 10; del_pct = 45; end
        default: begin add_pct = 30; del_pct = 25; end
      endcase
      tsel = $urandom_range(0, 2);
      roll = $urandom_range(0, 99);
      // Add and delete codes come in pairs per table; check codes run in table order.
      if (roll < add_pct)
        cmd = CMD_W'(CMD_ADD_BREAK + 2 * tsel);
      else if (roll < add_pct + del_pct)
        cmd = CMD_W'(CMD_DEL_BREAK + 2 * tsel);
      else if (roll < 96)
        cmd = CMD_W'(CMD_CHECK_PC + tsel);
      else
        cmd = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      a = ($urandom_range(0, 99) < 85) ? addr_pool[$urandom_range(0, POOL_SIZE - 1)]
                                       : $urandom;
      send_item(cmd, a, 1'b0, 1'b0, ST_DONE);
    end

    stim_done = 1'b1;
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("breakpoint_watchpoint_matcher verification clean");
    else
      $display("breakpoint_watchpoint_matcher verification failed");
    $finish;
  end

  initial begin : result_side
    int stall;
    watch_result_t want;
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 11);
      // One long hold lets the block back up and stall its request side.
      if (hold_rsp) begin
        hold_rsp = 1'b0;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result with none pending: hit=%0b status=%0d",
                                rsp_ch.hit, rsp_ch.status));
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.hit !== want.hit)
          flag_mismatch($sformatf("hit %0b, predicted %0b", rsp_ch.hit, want.hit));
        if (rsp_ch.status !== want.st)
          flag_mismatch($sformatf("status %0d, predicted %0d", rsp_ch.status, want.st));
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
        (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
      quiet_cycles <= 0;
    else if (!stim_done || pending_results.size() != 0)
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("breakpoint_watchpoint_matcher verification failed");
      $finish;
    end
  end

endmodule
